// ===== rtl/core/slri_pkg.sv =====
package slri_pkg;

  // default sizing
  localparam int unsigned DefCapacity   = 16;
  localparam int unsigned DefValueWidth = 32;

  // port field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned InValW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatW   = 2;
  localparam int unsigned OutValW = 32;
  localparam int unsigned CountW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/slri_cell.sv =====
module slri_cell #(
  parameter int unsigned VALUE_WIDTH = slri_pkg::DefValueWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slri_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic signed [VALUE_WIDTH-1:0] prev_entry_i,
  input  logic                          prev_ge_i,
  input  logic                          prev_valid_i,
  input  logic signed [VALUE_WIDTH-1:0] next_entry_i,
  input  logic                          next_valid_i,
  output logic signed [VALUE_WIDTH-1:0] entry_o,
  output logic                          valid_o,
  output logic                          ge_o,
  output logic                          hit_o
);
  import slri_pkg::*;

  logic signed [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                          valid_q, valid_d;
  logic                          ge;

  // an empty cell counts as above any value
  assign ge    = !valid_q || !(entry_q < value_i);
  // first cell not below the value, and equal to it
  assign hit_o = valid_q && ge && !prev_ge_i && (entry_q == value_i);

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign ge_o    = ge;

  // shift right on insert, left on remove, from the insert point on
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.ins && ge) begin
      entry_d = prev_ge_i ? prev_entry_i : value_i;
      valid_d = valid_q || prev_valid_i;
    end else if (ctrl_i.rem && ge) begin
      entry_d = next_entry_i;
      valid_d = next_valid_i;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

// ===== rtl/core/sorted_list_insert_remove.sv =====
// channel | direction | fields                             | handshake
// request | in        | command_i, value_i, position_i     | in_valid_i / in_ready_o
// result  | out       | status_o, read_value_o, entry_count_o | out_valid_o / out_ready_i
//
// one request per cycle while the output is free: all cells compare with the request
// value at once, and cells from the insert point on shift one place as it is taken.
// the result sits in an output register and is offered the next cycle.
// reset empties the row at once; no clearing pass is needed.
// a new request is taken while the result register is empty or being emptied.
module sorted_list_insert_remove #(
  parameter int unsigned CAPACITY    = slri_pkg::DefCapacity,
  parameter int unsigned VALUE_WIDTH = slri_pkg::DefValueWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [slri_pkg::CmdW-1:0]           command_i,
  input  logic signed [slri_pkg::InValW-1:0]  value_i,
  input  logic [slri_pkg::PosW-1:0]           position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [slri_pkg::StatW-1:0]          status_o,
  output logic signed [slri_pkg::OutValW-1:0] read_value_o,
  output logic [slri_pkg::CountW-1:0]         entry_count_o
);
  import slri_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned ReadN = (CAPACITY < (1 << PosW)) ? CAPACITY : (1 << PosW);

  logic                          accept;
  logic signed [VALUE_WIDTH-1:0] value;
  logic signed [VALUE_WIDTH-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]           valid;
  logic [CAPACITY-1:0]           ge;
  logic [CAPACITY-1:0]           hit;
  logic                          found;
  logic                          full;
  cell_ctrl_t                    ctrl;
  logic signed [VALUE_WIDTH-1:0] rd_entry;

  logic [CntW-1:0]          count_q, count_d;
  logic                     out_valid_q;
  logic [StatW-1:0]         status_q, status_d;
  logic signed [OutValW-1:0] rdata_q, rdata_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // request value wrapped to the stored width
  assign value = VALUE_WIDTH'(value_i);
  assign found = |hit;
  assign full  = (count_q == CntW'(CAPACITY));

  // shift controls
  always_comb begin
    ctrl.ins = accept && (command_i == CMD_INSERT) && !full;
    ctrl.rem = accept && (command_i == CMD_REMOVE) && found;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] prev_entry, next_entry;
    logic                          prev_ge, prev_valid, next_valid;
    if (i == 0) begin : g_head
      assign prev_entry = value;
      assign prev_ge    = 1'b0;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_entry = entry[i-1];
      assign prev_ge    = ge[i-1];
      assign prev_valid = valid[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entry[i];
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_entry = entry[i+1];
      assign next_valid = valid[i+1];
    end
    slri_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .value_i     (value),
      .prev_entry_i(prev_entry),
      .prev_ge_i   (prev_ge),
      .prev_valid_i(prev_valid),
      .next_entry_i(next_entry),
      .next_valid_i(next_valid),
      .entry_o     (entry[i]),
      .valid_o     (valid[i]),
      .ge_o        (ge[i]),
      .hit_o       (hit[i])
    );
  end

  // read select over the addressable cells
  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < ReadN; i++) begin
      if (position_i == PosW'(i)) begin
        rd_entry = entry[i];
      end
    end
  end

  // result and count
  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    rdata_d  = '0;
    case (command_i)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          count_d = count_q - CntW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (32'(position_i) >= 32'(count_q)) begin
          status_d = ST_BAD_INDEX;
        end else begin
          rdata_d = OutValW'(rd_entry);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  logic [CountW-1:0] cnt_out_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      rdata_q   <= rdata_d;
      cnt_out_q <= CountW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = rdata_q;
  assign entry_count_o = cnt_out_q;

endmodule
